// ===== hdl/byte_pattern_contains_assert.svh =====
// Assertion macros shared by the byte pattern finder modules.
// Include by bare file name; each use stands on a line of its own.
`ifndef BYTE_PATTERN_CONTAINS_ASSERT_SVH
`define BYTE_PATTERN_CONTAINS_ASSERT_SVH

// Invariant checked at every rising clock edge outside reset.
`define BPC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Same-cycle implication.
`define BPC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BPC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/bpc_pkg.sv =====
// Package for the byte pattern finder: command codes, queued op type, sizes.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package bpc_pkg;

   localparam int MAX_PATTERN_DEFAULT = 16;
   localparam int CMD_W               = 2;
   localparam int BYTE_W              = 8;
   localparam int RSP_DATA_W          = 8;
   // entries in the queue between front and back; a power of two
   localparam int QUEUE_DEPTH         = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR    = 2'd0,
      CMD_APPEND   = 2'd1,
      CMD_HAYSTACK = 2'd2,
      CMD_FINISH   = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type           cmd;
      logic              is_result;
      logic [BYTE_W-1:0] value;
   } op_type;

endpackage

// ===== hdl/bpc_front.sv =====
// Front end of the byte pattern finder: takes input items, classifies them
// and holds them in a short queue for the back end. Uses bpc_pkg.
`timescale 1ns / 1ps

module bpc_front
   import bpc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [CMD_W-1:0]  req_tuser,   // [1:0] command
   input  logic [BYTE_W-1:0] req_tdata,   // [7:0] byte_value
   output logic              op_valid,
   output op_type            op,
   input  logic              op_ready
);

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   op_type          q_ff [QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   op_type          op_in;
   logic            push;
   logic            pop;

   always_comb begin
      op_in.cmd       = cmd_type'(req_tuser);
      op_in.is_result = (op_in.cmd == CMD_FINISH);
      op_in.value     = req_tdata;
   end

   assign req_tready = (count_ff != CntW'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign op_valid   = (count_ff != '0);
   assign op         = q_ff[rd_ptr_ff];
   assign pop        = op_valid && op_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PtrW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PtrW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= op_in;
      end
   end

`include "byte_pattern_contains_assert.svh"

   `BPC_ASSERT(a_count_range, clock, reset, count_ff <= CntW'(QUEUE_DEPTH), "queue overfilled")
   `BPC_ASSERT_NEXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + CntW'(1), "queue count missed a push")
   `BPC_ASSERT_NEXT(a_count_down, clock, reset, pop && !push, count_ff == $past(count_ff) - CntW'(1), "queue count missed a pop")

endmodule

// ===== hdl/bpc_back.sv =====
// Back end of the byte pattern finder: pattern store, haystack window,
// parallel compare and the result register. Uses bpc_pkg.
`timescale 1ns / 1ps

module bpc_back
   import bpc_pkg::*;
#(
   parameter int MaxPattern = MAX_PATTERN_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  op_valid,
   input  op_type                op,
   output logic                  op_ready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int LenW = $clog2(MaxPattern + 1);

   // Pattern kept newest-append first, so entry j lines up with window
   // entry j (the byte seen j items ago) for the current length.
   logic [BYTE_W-1:0]     pat_ff [MaxPattern];
   logic [BYTE_W-1:0]     win_ff [MaxPattern];
   logic [BYTE_W-1:0]     win_in [MaxPattern];
   logic [LenW-1:0]       len_ff, len_in;
   logic [LenW-1:0]       seen_ff, seen_in, seen_next;
   logic                  match_ff, match_in;
   logic                  ovf_ff, ovf_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [MaxPattern-1:0] hit;
   logic                  window_match;
   logic                  pat_full;
   logic                  exec;

   assign op_ready   = !op.is_result || !rsp_valid_ff || rsp_tready;
   assign exec       = op_valid && op_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign pat_full   = (len_ff == LenW'(MaxPattern));

   always_comb begin
      win_in[0] = op.value;
      for (int j = 1; j < MaxPattern; j++) begin
         win_in[j] = win_ff[j-1];
      end
   end

   assign seen_next = (seen_ff == LenW'(MaxPattern)) ? seen_ff : seen_ff + LenW'(1);

   // positions past the pattern length always agree
   always_comb begin
      for (int j = 0; j < MaxPattern; j++) begin
         hit[j] = (win_in[j] == pat_ff[j]) || (LenW'(j) >= len_ff);
      end
   end

   assign window_match = (len_ff != '0) && (seen_next >= len_ff) && (&hit);

   always_comb begin
      len_in       = len_ff;
      seen_in      = seen_ff;
      match_in     = match_ff;
      ovf_in       = ovf_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (exec) begin
         unique case (op.cmd)
            CMD_CLEAR: begin
               len_in = '0;
               ovf_in = 1'b0;
            end
            CMD_APPEND: begin
               if (pat_full) begin
                  ovf_in = 1'b1;
               end else begin
                  len_in = len_ff + LenW'(1);
               end
            end
            CMD_HAYSTACK: begin
               seen_in  = seen_next;
               match_in = match_ff || window_match;
            end
            CMD_FINISH: begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(RSP_DATA_W-2){1'b0}}, ovf_ff,
                               (len_ff == '0) || match_ff};
               seen_in      = '0;
               match_in     = 1'b0;
            end
            default: begin
               len_in = len_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         seen_ff      <= '0;
         match_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         seen_ff      <= seen_in;
         match_ff     <= match_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Window entries are only compared once the byte count covers them,
   // so the window needs no reset or clear.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (exec && op.cmd == CMD_HAYSTACK) begin
         win_ff <= win_in;
      end
      if (exec && op.cmd == CMD_APPEND && !pat_full) begin
         pat_ff[0] <= op.value;
         for (int j = 1; j < MaxPattern; j++) begin
            pat_ff[j] <= pat_ff[j-1];
         end
      end
   end

`include "byte_pattern_contains_assert.svh"

   `BPC_ASSERT(a_len_range, clock, reset, len_ff <= LenW'(MaxPattern), "pattern length past capacity")
   `BPC_ASSERT(a_seen_range, clock, reset, seen_ff <= LenW'(MaxPattern), "byte count past saturation")
   `BPC_ASSERT_IMP(a_match_src, clock, reset, $rose(match_ff), $past(exec && op.cmd == CMD_HAYSTACK), "match flag set without a haystack item")
   `BPC_ASSERT_NEXT(a_finish_rsp, clock, reset, exec && op.is_result, rsp_valid_ff, "finish produced no result")

endmodule

// ===== hdl/byte_pattern_contains.sv =====
// Channel   Dir  Handshake              Payload
// req_      in   req_tvalid/req_tready  tuser[1:0] command, tdata[7:0] byte_value
// rsp_      out  rsp_tvalid/rsp_tready  tdata[0] found, tdata[1] pattern_overflow
//
// One item per cycle sustained unless a waiting result stalls a finish item; an accepted item
// passes the front queue to the back end, and a finish result is offered from a register.
// The cycle is set by the window compare: MaxPattern byte compares and an AND.
// Synchronous reset clears control state; no clearing pass is needed.
// A waiting result stalls only finish items; the two-entry queue lets the
// front keep accepting while the back end waits.
// Top level of the streaming byte pattern finder; uses bpc_pkg, bpc_front
// and bpc_back.
`timescale 1ns / 1ps

module byte_pattern_contains
   import bpc_pkg::*;
#(
   parameter int MaxPattern = MAX_PATTERN_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [CMD_W-1:0]      req_tuser,   // [1:0] command
   input  logic [BYTE_W-1:0]     req_tdata,   // [7:0] byte_value
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // [0] found, [1] pattern_overflow, [7:2] zero
);

   logic   op_valid;
   logic   op_ready;
   op_type op;

   bpc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .op_valid   (op_valid),
      .op         (op),
      .op_ready   (op_ready)
   );

   bpc_back #(
      .MaxPattern (MaxPattern)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .op_valid   (op_valid),
      .op         (op),
      .op_ready   (op_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
